>>> sv/bfiq_pkg.sv
// Package with shared types and constants of the Bloom filter block.
`default_nettype none
package bfiq_pkg;
  localparam int MaxFilterBits = 65536;
  localparam int MaxKeyBytes   = 64;
  localparam int MaxHashes     = 32;
  localparam int StoreWords    = (MaxFilterBits + 63) / 64;
  localparam int WordAw        = $clog2(StoreWords);
  localparam int KeyAw         = $clog2(MaxKeyBytes);
  localparam int PosW          = $clog2(MaxFilterBits);
  localparam logic [31:0] MixMul = 32'h5bd1e995;

  localparam logic CmdInsert = 1'b0;
  localparam logic CmdQuery  = 1'b1;

  localparam logic [0:0] RegFilterBits = 1'b0;
  localparam logic [0:0] RegHashCount  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_step;     // write one zero word of the filter store
    logic buf_write;      // store one key byte
    logic hash_start;     // load the seed and length for one hash
    logic block_load;     // fetch the next four key bytes
    logic block_mix_a;    // k * m
    logic block_mix_b;    // k ^= k >> 24, then k * m
    logic block_mix_c;    // h * m, then h ^= k
    logic tail_step;      // fold tail bytes and multiply
    logic fin_a;          // h ^= h >> 13, then * m
    logic fin_b;          // h ^= h >> 15
    logic mod_start;      // begin the modulo reduction
    logic mod_step;       // one restoring step
    logic mem_read;       // read the word holding the bit
    logic mem_update;     // set or test the bit
    logic key_done;       // count the insert and clear byte position
  } bfiq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic blocks_left;
    logic tail_nonzero;
    logic mod_last;
    logic hashes_left;
  } bfiq_stat_t;
endpackage
`default_nettype wire

>>> sv/bloom_filter_insert_query.sv
// Top level of the Bloom filter: APB registers, stream ports, controller and datapath.
// A final byte yields its result once the shared hash unit and the 32-step bit-serial
// modulo have run every hash pass over the key. One key at a time; after reset a
// clearing pass writes all 1024 store words, one a cycle, before the first input
// transaction is taken; configuration resets to 65536 bits, 4 hashes.
`default_nettype none
module bloom_filter_insert_query (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // key_byte[7:0], key_length[14:8], zero
  input  wire logic        s_axis_tuser,   // command
  input  wire logic        s_axis_tlast,   // last_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // maybe_present[0], inserted_count[32:1], zero
  output logic             m_axis_tuser,   // was_insert
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import bfiq_pkg::*;

  logic [16:0] filter_bits;
  logic [5:0]  hash_count;
  bfiq_cmd_t   cmd;
  bfiq_stat_t  stat;
  logic        maybe_present;
  logic [31:0] inserted_count;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_bits <= 17'(MaxFilterBits);
      hash_count  <= 6'd4;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      if (paddr[2] == RegFilterBits) filter_bits <= pwdata[16:0];
      else                           hash_count  <= pwdata[5:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      if (paddr[2] == RegFilterBits) prdata = {15'd0, filter_bits};
      else                           prdata = {26'd0, hash_count};
    end
  end

  bfiq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_last   (s_axis_tlast),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  bfiq_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .command        (s_axis_tuser),
    .key_byte       (s_axis_tdata[7:0]),
    .key_length     (s_axis_tdata[14:8]),
    .filter_bits    (filter_bits),
    .hash_count     (hash_count),
    .maybe_present  (maybe_present),
    .inserted_count (inserted_count),
    .was_insert     (m_axis_tuser)
  );

  assign m_axis_tdata = {7'd0, inserted_count, maybe_present};
endmodule
`default_nettype wire

>>> sv/bfiq_datapath.sv
// Datapath: key buffer, MurmurHash2 unit, modulo unit and filter store.
`default_nettype none
module bfiq_datapath (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire bfiq_pkg::bfiq_cmd_t cmd,
  output bfiq_pkg::bfiq_stat_t    stat,
  input  wire logic               command,
  input  wire logic [7:0]         key_byte,
  input  wire logic [6:0]         key_length,
  input  wire logic [16:0]        filter_bits,
  input  wire logic [5:0]         hash_count,
  output logic                    maybe_present,
  output logic [31:0]             inserted_count,
  output logic                    was_insert
);
  import bfiq_pkg::*;

  logic [31:0] key_buffer [MaxKeyBytes/4];
  logic [KeyAw:0] byte_position;
  logic [KeyAw:0] len;
  logic [KeyAw:0] rest;
  logic [KeyAw-3:0] rd_ptr;
  logic [31:0] rd_word;
  logic [31:0] h, k;
  logic [6:0]  seed;
  logic [5:0]  k_lim;
  logic [16:0] m_lim;
  logic [PosW:0] m_mod;
  logic [31:0] rem_q;
  logic [5:0]  mod_cnt;
  logic [WordAw:0] clr_addr;
  logic [63:0] filter_store [StoreWords];
  logic [63:0] rd_store;
  logic [PosW-1:0] pos;
  logic        op;
  logic        present;
  logic [31:0] insert_total;
  logic [32:0] trial;

  // Key bytes are packed four to a word; tail bytes beyond the key are masked later.
  always_ff @(posedge clk) begin
    if (cmd.buf_write && !byte_position[KeyAw]) begin
      key_buffer[byte_position[KeyAw-1:2]][{byte_position[1:0], 3'b000} +: 8] <= key_byte;
    end
    rd_word <= key_buffer[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      filter_store[clr_addr[WordAw-1:0]] <= '0;
    end else if (cmd.mem_update && op == CmdInsert) begin
      filter_store[pos[PosW-1:6]] <= rd_store | (64'd1 << pos[5:0]);
    end
    if (cmd.mem_read) begin
      rd_store <= filter_store[pos[PosW-1:6]];
    end
  end

  always_comb begin
    k_lim = (hash_count > 6'(MaxHashes)) ? 6'(MaxHashes) : hash_count;
    m_lim = (filter_bits == 17'd0) ? 17'd1 :
            (filter_bits > 17'(MaxFilterBits)) ? 17'(MaxFilterBits) : filter_bits;
    trial = {rem_q[31], rem_q} - {16'd0, m_mod[PosW:0]};
    stat.clear_last   = (clr_addr == (WordAw+1)'(StoreWords - 1));
    stat.blocks_left  = (rest >= (KeyAw+1)'(4));
    stat.tail_nonzero = (rest != '0);
    stat.mod_last     = (mod_cnt == 6'd1);
    stat.hashes_left  = ({1'b0, seed[5:0]} < {1'b0, k_lim}) && !seed[6];
  end

  logic [31:0] tail_x;
  always_comb begin
    tail_x = h;
    if (rest == (KeyAw+1)'(3)) tail_x = tail_x ^ {8'd0, rd_word[23:16], 16'd0};
    if (rest >= (KeyAw+1)'(2)) tail_x = tail_x ^ {16'd0, rd_word[15:8], 8'd0};
    tail_x = tail_x ^ {24'd0, rd_word[7:0]};
  end

  // Restoring remainder: the hash is reduced one quotient bit a step.
  logic [63:0] shreg;
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr      <= '0;
      byte_position <= '0;
      insert_total  <= '0;
      seed          <= '0;
    end else begin
      if (cmd.clear_step) clr_addr <= clr_addr + (WordAw+1)'(1);
      if (cmd.buf_write && byte_position < (KeyAw+1)'(MaxKeyBytes)) begin
        byte_position <= byte_position + (KeyAw+1)'(1);
      end
      if (cmd.key_done) begin
        byte_position <= '0;
        seed <= '0;
        if (op == CmdInsert && insert_total != '1) insert_total <= insert_total + 32'd1;
      end
      if (cmd.mem_update) seed <= seed + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.buf_write) begin
      op  <= command;
      len <= (key_length == 7'd0) ?
             ((byte_position < (KeyAw+1)'(MaxKeyBytes)) ?
              byte_position + (KeyAw+1)'(1) : byte_position) :
             (key_length > 7'(MaxKeyBytes)) ? (KeyAw+1)'(MaxKeyBytes) : (KeyAw+1)'(key_length);
      present <= 1'b1;
      m_mod   <= (PosW+1)'(m_lim);
    end
    if (cmd.hash_start) begin
      h      <= {26'd0, seed[5:0]} ^ {{(31-KeyAw){1'b0}}, len};
      rest   <= len;
      rd_ptr <= '0;
    end
    if (cmd.block_load) begin
      rd_ptr <= rd_ptr + (KeyAw-2)'(1);
      rest   <= rest - (KeyAw+1)'(4);
    end
    if (cmd.block_mix_a) k <= rd_word * MixMul;
    if (cmd.block_mix_b) k <= (k ^ (k >> 24)) * MixMul;
    if (cmd.block_mix_c) h <= (h * MixMul) ^ k;
    if (cmd.tail_step)   h <= tail_x * MixMul;
    if (cmd.fin_a)       h <= (h ^ (h >> 13)) * MixMul;
    if (cmd.fin_b)       h <= h ^ (h >> 15);
    if (cmd.mod_start) begin
      shreg   <= {32'd0, h};
      mod_cnt <= 6'd32;
    end
    if (cmd.mod_step) begin
      mod_cnt <= mod_cnt - 6'd1;
      shreg   <= {(trial[32] ? rem_q : trial[31:0]), shreg[30:0], 1'b0};
    end
    if (cmd.mem_update && op == CmdQuery && !rd_store[pos[5:0]]) present <= 1'b0;
  end

  // rem_q is the partial remainder shifted up with the next hash bit brought in.
  always_comb begin
    rem_q = {shreg[62:32], shreg[31]};
    pos   = shreg[32 +: PosW];
  end

  assign maybe_present  = (op == CmdInsert) ? 1'b1 : present;
  assign inserted_count = (op == CmdInsert && insert_total != '1) ?
                          insert_total + 32'd1 : insert_total;
  assign was_insert     = (op == CmdInsert);
endmodule
`default_nettype wire

>>> sv/bfiq_ctrl.sv
// Controller state machine sequencing hash passes and the store clear.
`default_nettype none
module bfiq_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_last,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output bfiq_pkg::bfiq_cmd_t     cmd,
  input  wire bfiq_pkg::bfiq_stat_t stat
);
  import bfiq_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SEED, S_LOAD, S_MIXA, S_MIXB, S_MIXC, S_TAIL,
    S_FINA, S_FINB, S_MODS, S_MOD, S_READ, S_UPD, S_OUT
  } state_t;

  state_t state;
  logic   acc;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign acc       = in_valid && in_ready;

  always_comb begin
    cmd = '0;
    cmd.clear_step  = (state == S_CLEAR);
    cmd.buf_write   = acc;
    cmd.hash_start  = (state == S_SEED) && stat.hashes_left;
    cmd.block_load  = (state == S_LOAD) && stat.blocks_left;
    cmd.block_mix_a = (state == S_MIXA);
    cmd.block_mix_b = (state == S_MIXB);
    cmd.block_mix_c = (state == S_MIXC);
    cmd.tail_step   = (state == S_TAIL);
    cmd.fin_a       = (state == S_FINA);
    cmd.fin_b       = (state == S_FINB);
    cmd.mod_start   = (state == S_MODS);
    cmd.mod_step    = (state == S_MOD);
    cmd.mem_read    = (state == S_READ);
    cmd.mem_update  = (state == S_UPD);
    cmd.key_done    = (state == S_OUT) && out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      unique case (state)
        S_CLEAR: if (stat.clear_last) state <= S_IDLE;
        S_IDLE:  if (acc && in_last) state <= S_SEED;
        S_SEED:  state <= stat.hashes_left ? S_LOAD : S_OUT;
        S_LOAD: begin
          // The word read registers in this cycle feeds either a block or the tail.
          if (stat.blocks_left)       state <= S_MIXA;
          else if (stat.tail_nonzero) state <= S_TAIL;
          else                        state <= S_FINA;
        end
        S_MIXA:  state <= S_MIXB;
        S_MIXB:  state <= S_MIXC;
        S_MIXC:  state <= S_LOAD;
        S_TAIL:  state <= S_FINA;
        S_FINA:  state <= S_FINB;
        S_FINB:  state <= S_MODS;
        S_MODS:  state <= S_MOD;
        S_MOD:   if (stat.mod_last) state <= S_READ;
        S_READ:  state <= S_UPD;
        S_UPD:   state <= S_SEED;
        S_OUT:   if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_ready_out: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("input and output open together");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_step |-> !in_ready) else $error("input taken during clear");
endmodule
`default_nettype wire

>>> test/bfiq_checker.sv
// Checker for the Bloom filter: watches the streams and APB writes, predicts and compares.
module bfiq_checker
  import bfiq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,
  input  wire logic        s_axis_tuser,
  input  wire logic        s_axis_tlast,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [39:0] m_axis_tdata,
  input  wire logic        m_axis_tuser,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output int               errors,
  output int               pending
);
  typedef struct packed {
    logic        present;
    logic [31:0] count;
    logic        insert;
  } answer_t;

  logic [MaxFilterBits-1:0] bits_set;
  logic [7:0]  key_bytes [MaxKeyBytes];
  int unsigned bytes_in;
  logic [31:0] inserts;
  logic [16:0] size_reg;
  logic [5:0]  hashes_reg;
  answer_t     answers [$];

  function automatic logic [31:0] murmur(int unsigned len, logic [31:0] seed);
    logic [31:0] h, k;
    int unsigned p, rest;
    h = seed ^ len;
    p = 0;
    rest = len;
    while (rest >= 4) begin
      k = {key_bytes[p+3], key_bytes[p+2], key_bytes[p+1], key_bytes[p]};
      k = k * MixMul;
      k ^= k >> 24;
      k = k * MixMul;
      h = h * MixMul;
      h ^= k;
      p += 4;
      rest -= 4;
    end
    if (rest == 3) h ^= {8'h0, key_bytes[p+2], 16'h0};
    if (rest >= 2) h ^= {16'h0, key_bytes[p+1], 8'h0};
    if (rest >= 1) begin
      h ^= {24'h0, key_bytes[p]};
      h = h * MixMul;
    end
    h ^= h >> 13;
    h = h * MixMul;
    h ^= h >> 15;
    return h;
  endfunction

  // Handles one accepted key byte; a final byte queues one answer.
  task automatic take_byte(logic cmd, logic [7:0] b, logic [6:0] klen, logic fin);
    int unsigned m, k, len, pos;
    answer_t a;
    logic hit;
    if (bytes_in < MaxKeyBytes) begin
      key_bytes[bytes_in] = b;
      bytes_in++;
    end
    if (!fin) return;
    m = (size_reg == 0) ? 1 : size_reg;
    if (m > MaxFilterBits) m = MaxFilterBits;
    k = (hashes_reg > MaxHashes) ? MaxHashes : hashes_reg;
    len = (klen == 0) ? bytes_in : klen;
    if (len > MaxKeyBytes) len = MaxKeyBytes;
    hit = 1'b1;
    for (int i = 0; i < k; i++) begin
      pos = murmur(len, i) % m;
      if (cmd == CmdInsert) bits_set[pos] = 1'b1;
      else if (!bits_set[pos]) hit = 1'b0;
    end
    if (cmd == CmdInsert && inserts != 32'hFFFF_FFFF) inserts++;
    bytes_in = 0;
    a.present = (cmd == CmdInsert) ? 1'b1 : hit;
    a.count = inserts;
    a.insert = (cmd == CmdInsert);
    answers.push_back(a);
  endtask

  always @(posedge clk) begin
    answer_t got, want;
    if (rst) begin
      bits_set = '0;
      bytes_in = 0;
      inserts = 0;
      size_reg = 17'd65536;
      hashes_reg = 6'd4;
      answers.delete();
      errors = 0;
    end else begin
      if (psel && penable && pwrite) begin
        if (paddr[2] == RegFilterBits) size_reg = pwdata[16:0];
        else hashes_reg = pwdata[5:0];
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.present = m_axis_tdata[0];
        got.count = m_axis_tdata[32:1];
        got.insert = m_axis_tuser;
        if (answers.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors++;
        end else begin
          want = answers.pop_front();
          if (got.present !== want.present)
            $display("%0t: maybe_present expected %0d actual %0d",
                     $time, want.present, got.present);
          if (got.count !== want.count)
            $display("%0t: inserted_count expected %0d actual %0d",
                     $time, want.count, got.count);
          if (got.insert !== want.insert)
            $display("%0t: was_insert expected %0d actual %0d",
                     $time, want.insert, got.insert);
          if (got !== want) errors++;
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        take_byte(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[14:8], s_axis_tlast);
    end
    pending = answers.size();
  end
endmodule

>>> test/tb_bloom_filter_insert_query.sv
// Testbench top for the Bloom filter: clock, reset, stimulus, APB writes and verdict.
module tb_bloom_filter_insert_query;
  import bfiq_pkg::*;

  logic        clk, rst;
  logic        s_axis_tvalid, s_axis_tready, s_axis_tuser, s_axis_tlast;
  logic [15:0] s_axis_tdata;   // key_byte[7:0], key_length[14:8], zero
  logic        m_axis_tvalid, m_axis_tready, m_axis_tuser;
  logic [39:0] m_axis_tdata;   // maybe_present[0], inserted_count[32:1], zero
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  int          errors, pending;
  int          send_idle, recv_stall, hold_off;
  logic [7:0]  saved_key [MaxKeyBytes];

  bloom_filter_insert_query dut (.*);
  bfiq_checker chk (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("[bloom_filter_insert_query] ERROR");
    $finish;
  end

  // Receiver: random stalls, or a long hold-off when requested.
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic reg_write(logic [2:0] addr, logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
  endtask

  // The valid stays up after a transaction until the next byte or an idle cycle replaces it.
  task automatic send_byte(logic cmd, logic [7:0] b, logic [6:0] klen, logic fin);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= cmd;
    s_axis_tlast <= fin;
    s_axis_tdata <= {1'b0, klen, b};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // One key of n received bytes; length field zero, exact, or at least the count received.
  task automatic send_key(logic cmd, int n, int lmode, logic reuse);
    logic [6:0] klen;
    for (int i = 0; i < n; i++) begin
      if (!reuse || i >= MaxKeyBytes) saved_key[i % MaxKeyBytes] = 8'($urandom);
      klen = (lmode == 0) ? 7'd0 : (lmode == 1) ? 7'(n) : 7'($urandom_range(n, 127));
      // Never read buffer entries beyond the bytes ever written.
      if (lmode == 2 && n < MaxKeyBytes) klen = 7'(n);
      send_byte(cmd, saved_key[i % MaxKeyBytes], klen, i == n - 1);
    end
  endtask

  task automatic drain;
    s_axis_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4000) @(posedge clk);
  endtask

  initial begin
    int n;
    rst = 1;
    s_axis_tvalid = 0; s_axis_tdata = 0; s_axis_tuser = 0; s_axis_tlast = 0;
    m_axis_tready = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    send_idle = 0; recv_stall = 0; hold_off = 0;
    repeat (11) @(posedge clk);
    rst <= 0;

    // Directed: fill the buffer fully once, then the extremes.
    send_key(CmdInsert, 64, 1, 0);
    send_key(CmdQuery, 64, 1, 1);
    send_key(CmdInsert, 70, 2, 1);
    send_byte(CmdQuery, 8'hFF, 7'd127, 1);
    send_byte(CmdInsert, 8'h00, 7'd1, 1);
    send_key(CmdQuery, 3, 0, 0);
    send_key(CmdInsert, 5, 0, 0);
    send_key(CmdQuery, 5, 1, 1);
    drain();
    reg_write(3'd4, 32'd0);
    reg_write(3'd0, 32'd0);
    send_key(CmdInsert, 4, 1, 0);
    send_key(CmdQuery, 2, 1, 0);
    drain();
    reg_write(3'd4, 32'h3F);
    reg_write(3'd0, 32'h1FFFF);
    send_key(CmdInsert, 2, 1, 0);
    send_key(CmdQuery, 2, 1, 1);
    drain();
    reg_write(3'd0, 32'd1);
    reg_write(3'd4, 32'd1);
    send_key(CmdQuery, 1, 1, 0);
    drain();

    // Long hold-off while offering bytes so the block backs up.
    hold_off = 3000;
    for (int i = 0; i < 6; i++) send_key($urandom_range(1), 3, 1, 0);

    // Random phases with assorted settings.
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      reg_write(3'd0, (ph % 3 == 0) ? 32'd64 : $urandom_range(1, 70000));
      reg_write(3'd4, (ph == 7) ? 32'd32 : $urandom_range(0, 8));
      send_idle = (ph % 4 == 1 || ph % 4 == 3) ? (ph % 4 == 3 ? 35 : 69) : 0;
      recv_stall = (ph % 4 == 2) ? 69 : (ph % 4 == 3) ? 35 : 0;
      for (int i = 0; i < 38; i++) begin
        n = ($urandom_range(19) == 0) ? $urandom_range(1, 66) : $urandom_range(1, 6);
        send_key($urandom_range(1), n, $urandom_range(2), $urandom_range(3) == 0);
      end
    end
    drain();

    if (errors == 0) $display("[bloom_filter_insert_query] OK");
    else $display("[bloom_filter_insert_query] ERROR");
    $finish;
  end
endmodule
